FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the text generator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted (active low)
`define GRRR_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block clock and reset
`define GRRR_CHECK(name, prop, msg) \
    `GRRR_ASSERT(name, aclk, aresetn, prop, msg)

`endif

FILE: rtl/grrr_pkg.sv
// ----------------------------------------------------------------------------
// grrr_pkg
// Shared types, font ROM and helpers for the glyph row-run rectangle
// text generator.
// ----------------------------------------------------------------------------
`default_nettype none

package grrr_pkg;

    // Default build values
    localparam int CELL_SIZE_DEF     = 2;
    localparam int GLYPH_ADVANCE_DEF = 12;
    localparam int GLYPH_ROWS_DEF    = 7;
    localparam int GLYPH_COLS_DEF    = 5;

    // Font ROM geometry
    localparam int ROM_GLYPHS = 18;
    localparam int ROM_ROWS   = 7;
    localparam int ROM_ROW_W  = 3;
    localparam int GLYPH_W    = 5;

    // Rectangle cap per character
    localparam int MAX_RECTS = 16;
    localparam int CNT_W     = 5;

    // Coordinate math width: 16-bit inputs plus small offsets
    localparam int SUM_W = 18;

    // Character codes used for case folding
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_LOWER_M = 8'h6D;
    localparam logic [7:0] CH_LOWER_S = 8'h73;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    localparam logic [7:0] FONT_CODES [ROM_GLYPHS] = '{
        8'h20, 8'h2E, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h46, 8'h50, 8'h53, 8'h4D, 8'h6D, 8'h73
    };

    localparam logic [7:0] FONT_ROM [ROM_GLYPHS][ROM_ROWS] = '{
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0C, 8'h0C},
        '{8'h0E, 8'h11, 8'h13, 8'h15, 8'h19, 8'h11, 8'h0E},
        '{8'h04, 8'h0C, 8'h04, 8'h04, 8'h04, 8'h04, 8'h0E},
        '{8'h0E, 8'h11, 8'h01, 8'h02, 8'h04, 8'h08, 8'h1F},
        '{8'h0E, 8'h11, 8'h01, 8'h06, 8'h01, 8'h11, 8'h0E},
        '{8'h02, 8'h06, 8'h0A, 8'h12, 8'h1F, 8'h02, 8'h02},
        '{8'h1F, 8'h10, 8'h1E, 8'h01, 8'h01, 8'h11, 8'h0E},
        '{8'h06, 8'h08, 8'h10, 8'h1E, 8'h11, 8'h11, 8'h0E},
        '{8'h1F, 8'h01, 8'h02, 8'h04, 8'h08, 8'h08, 8'h08},
        '{8'h0E, 8'h11, 8'h11, 8'h0E, 8'h11, 8'h11, 8'h0E},
        '{8'h0E, 8'h11, 8'h11, 8'h0F, 8'h01, 8'h02, 8'h0C},
        '{8'h1F, 8'h10, 8'h10, 8'h1E, 8'h10, 8'h10, 8'h10},
        '{8'h1E, 8'h11, 8'h11, 8'h1E, 8'h10, 8'h10, 8'h10},
        '{8'h0F, 8'h10, 8'h10, 8'h0E, 8'h01, 8'h01, 8'h1E},
        '{8'h11, 8'h1B, 8'h15, 8'h15, 8'h11, 8'h11, 8'h11},
        '{8'h00, 8'h00, 8'h1A, 8'h15, 8'h15, 8'h15, 8'h15},
        '{8'h00, 8'h00, 8'h0F, 8'h10, 8'h0E, 8'h01, 8'h1E}
    };

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } grrr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_draw;
        logic out_free;
        logic step_done;
    } grrr_status_t;

    typedef struct packed {
        logic               known;
        logic [GLYPH_W-1:0] idx;
    } glyph_sel_t;

    // Fold lower case (except m and s) and find the glyph slot
    function automatic glyph_sel_t lookup_glyph(input logic [7:0] code);
        logic [7:0] ch;
        glyph_sel_t sel;
        ch = code;
        if (code >= CH_LOWER_A && code <= CH_LOWER_Z &&
            code != CH_LOWER_M && code != CH_LOWER_S) begin
            ch = code - CASE_DELTA;
        end
        sel = '0;
        for (int g = 0; g < ROM_GLYPHS; g++) begin
            if (FONT_CODES[g] == ch) begin
                sel.known = 1'b1;
                sel.idx   = GLYPH_W'(g);
            end
        end
        return sel;
    endfunction

    // One font row; slots past the table read blank
    function automatic logic [7:0] font_row(input logic [GLYPH_W-1:0] g,
                                            input logic [ROM_ROW_W-1:0] r);
        logic [7:0] bits;
        bits = '0;
        if (int'(g) < ROM_GLYPHS && int'(r) < ROM_ROWS) begin
            bits = FONT_ROM[g][r];
        end
        return bits;
    endfunction

    // Clamp to the signed 16-bit range
    function automatic logic [15:0] sat16(input logic [SUM_W-1:0] v);
        logic [15:0] res;
        if (!v[SUM_W-1] && v[SUM_W-2:15] != '0) begin
            res = 16'h7FFF;
        end else if (v[SUM_W-1] && v[SUM_W-2:15] != '1) begin
            res = 16'h8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/grrr_ctrl.sv
// ----------------------------------------------------------------------------
// grrr_ctrl
// Sequencer for the text generator: takes a character, then steps the run
// finder until the last rectangle of the glyph has been loaded out.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module grrr_ctrl
    import grrr_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire grrr_status_t status,
    output grrr_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;
    logic   take_draw;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && status.in_draw) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.step_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SCAN: begin
                cmd.step = status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Item taken that starts a drawn glyph
    assign take_draw = s_tvalid && s_tready && status.in_draw;

    `GRRR_CHECK(a_busy_after_draw, take_draw |=> !s_tready, "input taken mid-glyph")

endmodule

`default_nettype wire

FILE: rtl/grrr_dp.sv
// ----------------------------------------------------------------------------
// grrr_dp
// Datapath: pen and origin registers, glyph row scanner with a run finder,
// coordinate arithmetic with saturation, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module grrr_dp
    import grrr_pkg::*;
#(
    parameter int CELL_SIZE     = CELL_SIZE_DEF,
    parameter int GLYPH_ADVANCE = GLYPH_ADVANCE_DEF,
    parameter int GLYPH_ROWS    = GLYPH_ROWS_DEF,
    parameter int GLYPH_COLS    = GLYPH_COLS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic [39:0]  s_tdata,
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,
    output logic              m_tlast,
    input  wire grrr_cmd_t    cmd,
    output grrr_status_t      status
);

    localparam int EFF_ROWS = (GLYPH_ROWS < ROM_ROWS) ? GLYPH_ROWS : ROM_ROWS;
    localparam int ROW_W    = (EFF_ROWS > 1) ? $clog2(EFF_ROWS) : 1;
    localparam int COL_W    = $clog2(GLYPH_COLS + 1);

    // Row byte to a column vector, column 0 in bit 0
    function automatic logic [GLYPH_COLS-1:0] row_cols(input logic [7:0] bits);
        logic [GLYPH_COLS-1:0] v;
        for (int c = 0; c < GLYPH_COLS; c++) begin
            v[c] = bits[3'(GLYPH_COLS - 1 - c)];
        end
        return v;
    endfunction

    // Rows of a glyph that hold at least one set pixel
    function automatic logic [EFF_ROWS-1:0] glyph_rows(input logic [GLYPH_W-1:0] g);
        logic [EFF_ROWS-1:0] m;
        for (int r = 0; r < EFF_ROWS; r++) begin
            m[r] = |row_cols(font_row(g, ROM_ROW_W'(r)));
        end
        return m;
    endfunction

    // Character registers
    logic [15:0]          pen_x_reg;
    logic [15:0]          pen_x_next;
    logic [15:0]          draw_pen_reg;
    logic [15:0]          origin_y_reg;
    logic [GLYPH_W-1:0]   glyph_reg;
    logic [EFF_ROWS-1:0]  rows_nz_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [COL_W-1:0]     col_reg;
    logic [CNT_W-1:0]     count_reg;

    // Result register
    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic [63:0]          m_tdata_reg;
    logic                 m_tlast_reg;

    // Load side
    glyph_sel_t           in_sel;
    logic [EFF_ROWS-1:0]  in_rows_nz;
    logic [15:0]          base_pen;
    logic [SUM_W-1:0]     adv_sum;

    // Scan side
    logic [GLYPH_COLS-1:0] cur_cols;
    logic [GLYPH_COLS-1:0] from_col;
    logic [GLYPH_COLS-1:0] after_run;
    logic [EFF_ROWS-1:0]   later_row;
    logic [COL_W-1:0]      start_idx;
    logic [COL_W-1:0]      end_idx;
    logic                  have_start;
    logic                  have_end;
    logic                  run_found;
    logic                  emit;
    logic                  is_last;

    // Coordinates
    logic [SUM_W-1:0]     pen_ext;
    logic [SUM_W-1:0]     oy_ext;
    logic [SUM_W-1:0]     left_sum;
    logic [SUM_W-1:0]     right_sum;
    logic [SUM_W-1:0]     top_sum;
    logic [SUM_W-1:0]     bottom_sum;

    // Decode the incoming character and the pen it draws at
    always_comb begin
        in_sel     = lookup_glyph(s_tdata[7:0]);
        in_rows_nz = in_sel.known ? glyph_rows(in_sel.idx) : '0;
        base_pen   = s_tuser[0] ? s_tdata[23:8] : pen_x_reg;
        adv_sum    = {{(SUM_W-16){base_pen[15]}}, base_pen} + SUM_W'(GLYPH_ADVANCE);
        pen_x_next = sat16(adv_sum);
    end

    // Find the next run in the current row
    always_comb begin
        cur_cols   = row_cols(font_row(glyph_reg, ROM_ROW_W'(row_reg)));
        start_idx  = '0;
        have_start = 1'b0;
        end_idx    = COL_W'(GLYPH_COLS);
        have_end   = 1'b0;
        for (int c = 0; c < GLYPH_COLS; c++) begin
            from_col[c] = cur_cols[c] && (COL_W'(c) >= col_reg);
        end
        for (int c = 0; c < GLYPH_COLS; c++) begin
            if (!have_start && from_col[c]) begin
                start_idx  = COL_W'(c);
                have_start = 1'b1;
            end
        end
        for (int c = 0; c < GLYPH_COLS; c++) begin
            if (!have_end && COL_W'(c) > start_idx && !cur_cols[c]) begin
                end_idx  = COL_W'(c);
                have_end = 1'b1;
            end
        end
        for (int c = 0; c < GLYPH_COLS; c++) begin
            after_run[c] = cur_cols[c] && (COL_W'(c) >= end_idx);
        end
        for (int r = 0; r < EFF_ROWS; r++) begin
            later_row[r] = rows_nz_reg[r] && (ROW_W'(r) > row_reg);
        end
        run_found = |from_col;
        emit      = cmd.step && run_found;
        is_last   = (count_reg == CNT_W'(MAX_RECTS - 1)) ||
                    (!(|after_run) && !(|later_row));
    end

    // Rectangle corners, exact then clamped
    always_comb begin
        pen_ext    = {{(SUM_W-16){draw_pen_reg[15]}}, draw_pen_reg};
        oy_ext     = {{(SUM_W-16){origin_y_reg[15]}}, origin_y_reg};
        left_sum   = pen_ext + SUM_W'(start_idx) * SUM_W'(CELL_SIZE);
        right_sum  = pen_ext + SUM_W'(end_idx) * SUM_W'(CELL_SIZE);
        top_sum    = oy_ext + SUM_W'(row_reg) * SUM_W'(CELL_SIZE);
        bottom_sum = top_sum + SUM_W'(CELL_SIZE);
    end

    // Result register: set on a new rectangle, drop once taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_x_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (cmd.load) begin
                pen_x_reg <= pen_x_next;
            end
        end
    end

    // Scan and payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            draw_pen_reg <= base_pen;
            origin_y_reg <= s_tdata[39:24];
            glyph_reg    <= in_sel.idx;
            rows_nz_reg  <= in_rows_nz;
            row_reg      <= '0;
            col_reg      <= '0;
            count_reg    <= '0;
        end else if (cmd.step) begin
            if (run_found) begin
                col_reg   <= end_idx;
                count_reg <= count_reg + 1'b1;
            end else begin
                row_reg <= ROW_W'(row_reg + 1'b1);
                col_reg <= '0;
            end
        end
        if (emit) begin
            m_tdata_reg <= {sat16(bottom_sum), sat16(right_sum),
                            sat16(top_sum), sat16(left_sum)};
            m_tlast_reg <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    assign status.in_draw   = |in_rows_nz;
    assign status.out_free  = !m_tvalid_reg || m_tready;
    assign status.step_done = emit && is_last;

    `GRRR_CHECK(a_no_overwrite, emit |-> (!m_tvalid_reg || m_tready), "result overwritten")
    `GRRR_CHECK(a_rect_cap, emit |-> (count_reg < CNT_W'(MAX_RECTS)), "too many rectangles")

endmodule

`default_nettype wire

FILE: rtl/glyph_row_run_rectangles.sv
// ----------------------------------------------------------------------------
// glyph_row_run_rectangles
// On-screen text generator: one character in, one filled rectangle out for
// each horizontal run of set pixels in its 5x7 glyph.
//
//   channel  dir  tdata (low bit up)                          tuser / tlast
//   s_       in   char_code, origin_x, origin_y (40 bits)     first_of_string
//   m_       out  rect_left, rect_top, rect_right,            last_of_glyph
//                 rect_bottom (64 bits)
//
// A character is accepted, then the scan steps once per rectangle and once
// more to advance past each row before the row of its last rectangle; M has
// the most rectangles, 16, the last one on row 6. The scan uses a single run
// finder and a one-deep result register.
// Unknown and blank characters are accepted from idle and emit nothing.
// Reset (aresetn low, synchronous) clears the pen to zero and drops any
// pending result. A stalled m_tready holds the scan; input is taken again
// once the last rectangle is in the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_row_run_rectangles
    import grrr_pkg::*;
#(
    parameter int CELL_SIZE     = CELL_SIZE_DEF,
    parameter int GLYPH_ADVANCE = GLYPH_ADVANCE_DEF,
    parameter int GLYPH_ROWS    = GLYPH_ROWS_DEF,
    parameter int GLYPH_COLS    = GLYPH_COLS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [39:0]  s_tdata,   // char_code, origin_x, origin_y
    input  wire logic [0:0]   s_tuser,   // first_of_string
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,   // rect_left, rect_top, rect_right, rect_bottom
    output logic              m_tlast    // last_of_glyph
);

    grrr_cmd_t    cmd;
    grrr_status_t status;

    grrr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    grrr_dp #(
        .CELL_SIZE     (CELL_SIZE),
        .GLYPH_ADVANCE (GLYPH_ADVANCE),
        .GLYPH_ROWS    (GLYPH_ROWS),
        .GLYPH_COLS    (GLYPH_COLS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

`default_nettype wire

FILE: dv/glyph_rect_checker.sv
// ----------------------------------------------------------------------------
// glyph_rect_checker
// Watches both streams of the text generator, predicts the run rectangles
// of every accepted character from its own copy of the 5x7 font and of the
// pen, and compares each accepted rectangle with the oldest prediction.
// ----------------------------------------------------------------------------
module glyph_rect_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,    // char_code, origin_x, origin_y
    input  logic [0:0]  s_tuser,    // first_of_string
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,    // rect_left, rect_top, rect_right, rect_bottom
    input  logic        m_tlast,    // last_of_glyph
    output int          fail_count,
    output int          pending,
    output int          rect_total,
    output int          char_total
);

    localparam int CELL    = 2;
    localparam int ADVANCE = 12;
    localparam int ROWS    = 7;
    localparam int COLS    = 5;
    localparam int NGLYPH  = 18;
    localparam int ROMROWS = 7;
    localparam int RECT_CAP = 16;
    localparam int REPORT_LIMIT = 10;

    localparam logic [7:0] LOWER_A = 8'h61;
    localparam logic [7:0] LOWER_Z = 8'h7A;
    localparam logic [7:0] LOWER_M = 8'h6D;
    localparam logic [7:0] LOWER_S = 8'h73;
    localparam logic [7:0] FOLD_OFFSET = 8'h20;

    // Characters of the font, in table order
    localparam logic [7:0] CHARSET [NGLYPH] = '{
        8'h20, 8'h2E, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h46, 8'h50, 8'h53, 8'h4D, 8'h6D, 8'h73
    };

    // Row bitmaps, leftmost column in bit 4
    localparam logic [7:0] BITMAPS [NGLYPH][ROMROWS] = '{
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0C, 8'h0C},
        '{8'h0E, 8'h11, 8'h13, 8'h15, 8'h19, 8'h11, 8'h0E},
        '{8'h04, 8'h0C, 8'h04, 8'h04, 8'h04, 8'h04, 8'h0E},
        '{8'h0E, 8'h11, 8'h01, 8'h02, 8'h04, 8'h08, 8'h1F},
        '{8'h0E, 8'h11, 8'h01, 8'h06, 8'h01, 8'h11, 8'h0E},
        '{8'h02, 8'h06, 8'h0A, 8'h12, 8'h1F, 8'h02, 8'h02},
        '{8'h1F, 8'h10, 8'h1E, 8'h01, 8'h01, 8'h11, 8'h0E},
        '{8'h06, 8'h08, 8'h10, 8'h1E, 8'h11, 8'h11, 8'h0E},
        '{8'h1F, 8'h01, 8'h02, 8'h04, 8'h08, 8'h08, 8'h08},
        '{8'h0E, 8'h11, 8'h11, 8'h0E, 8'h11, 8'h11, 8'h0E},
        '{8'h0E, 8'h11, 8'h11, 8'h0F, 8'h01, 8'h02, 8'h0C},
        '{8'h1F, 8'h10, 8'h10, 8'h1E, 8'h10, 8'h10, 8'h10},
        '{8'h1E, 8'h11, 8'h11, 8'h1E, 8'h10, 8'h10, 8'h10},
        '{8'h0F, 8'h10, 8'h10, 8'h0E, 8'h01, 8'h01, 8'h1E},
        '{8'h11, 8'h1B, 8'h15, 8'h15, 8'h11, 8'h11, 8'h11},
        '{8'h00, 8'h00, 8'h1A, 8'h15, 8'h15, 8'h15, 8'h15},
        '{8'h00, 8'h00, 8'h0F, 8'h10, 8'h0E, 8'h01, 8'h1E}
    };

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] right;
        logic [15:0] bottom;
        logic        last;
    } rect_t;

    rect_t rect_queue[$];
    int    pen;
    int    mismatches;
    int    rects_seen;
    int    chars_seen;

    function automatic int clamp16(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic logic pixel_on(input logic [7:0] bits, input int col);
        int b;
        b = COLS - 1 - col;
        if (b < 0 || b > 7) return 1'b0;
        return bits[b];
    endfunction

    // Queue the rectangles of one character and advance the pen
    function automatic void draw_glyph_rects(input logic [7:0] code, input logic first,
                                             input logic [15:0] ox, input logic [15:0] oy);
        logic [7:0] ch;
        logic [7:0] bits;
        int         slot;
        int         n;
        int         col;
        int         start;
        int         top;
        int         y0;
        rect_t      batch [RECT_CAP];
        if (first) pen = int'($signed(ox));
        y0 = int'($signed(oy));
        ch = code;
        if (code >= LOWER_A && code <= LOWER_Z && code != LOWER_M && code != LOWER_S)
            ch = code - FOLD_OFFSET;
        slot = -1;
        for (int g = 0; g < NGLYPH; g++)
            if (CHARSET[g] == ch) slot = g;
        n = 0;
        if (slot >= 0) begin
            for (int row = 0; row < ROWS; row++) begin
                bits = (row < ROMROWS) ? BITMAPS[slot][row] : 8'h00;
                col = 0;
                while (col < COLS) begin
                    while (col < COLS && !pixel_on(bits, col)) col++;
                    if (col >= COLS) break;
                    start = col;
                    while (col < COLS && pixel_on(bits, col)) col++;
                    if (n >= RECT_CAP) break;
                    top = y0 + row * CELL;
                    batch[n].left   = 16'(clamp16(pen + start * CELL));
                    batch[n].top    = 16'(clamp16(top));
                    batch[n].right  = 16'(clamp16(pen + col * CELL));
                    batch[n].bottom = 16'(clamp16(top + CELL));
                    batch[n].last   = 1'b0;
                    n++;
                end
            end
        end
        if (n > 0) batch[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) rect_queue.push_back(batch[k]);
        pen = clamp16(pen + ADVANCE);
    endfunction

    function automatic void show_rect(input string tag, input rect_t r);
        $display("  %s: left %0d top %0d right %0d bottom %0d last %0b", tag,
                 $signed(r.left), $signed(r.top), $signed(r.right), $signed(r.bottom),
                 r.last);
    endfunction

    initial begin
        pen = 0;
        mismatches = 0;
        rects_seen = 0;
        chars_seen = 0;
        fail_count = 0;
        pending = 0;
        rect_total = 0;
        char_total = 0;
    end

    always @(posedge aclk) begin
        rect_t got;
        rect_t want;
        if (!aresetn) begin
            pen = 0;
        end else begin
            // Predict for an accepted character
            if (s_tvalid && s_tready) begin
                draw_glyph_rects(s_tdata[7:0], s_tuser[0], s_tdata[23:8], s_tdata[39:24]);
                chars_seen++;
            end
            // Compare an accepted rectangle with the oldest prediction
            if (m_tvalid && m_tready) begin
                got.left   = m_tdata[15:0];
                got.top    = m_tdata[31:16];
                got.right  = m_tdata[47:32];
                got.bottom = m_tdata[63:48];
                got.last   = m_tlast;
                rects_seen++;
                if (rect_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("[%0t] rectangle %0d with nothing expected", $realtime,
                                 rects_seen);
                        show_rect("actual", got);
                    end
                end else begin
                    want = rect_queue.pop_front();
                    if (got.left !== want.left || got.top !== want.top ||
                        got.right !== want.right || got.bottom !== want.bottom ||
                        got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("[%0t] rectangle %0d mismatch", $realtime, rects_seen);
                            show_rect("expected", want);
                            show_rect("actual  ", got);
                        end
                    end
                end
            end
        end
        fail_count <= mismatches;
        pending    <= rect_queue.size();
        rect_total <= rects_seen;
        char_total <= chars_seen;
    end

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the text generator with a directed set of characters and then with
// random strings, in bursts with random gaps, while the result side stalls
// on its own pattern. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb;

    localparam int RANDOM_ITEMS = 480;
    localparam int DRAIN_CYCLES = 40;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_STALL
    } rx_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;

    int fail_count;
    int pending;
    int rect_total;
    int char_total;

    int       burst_left = 0;
    int       directed_count = 0;
    rx_mode_t rx_mode = RX_OPEN;
    int       mode_timer = 0;
    int       stall_left = 0;

    string text_set = "0123456789 .FPSMmsfp";

    always #10 aclk = ~aclk;

    glyph_row_run_rectangles DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    glyph_rect_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending),
        .rect_total (rect_total),
        .char_total (char_total)
    );

    // Offer one item, inserting a gap when the current burst is used up
    task automatic send_char(input logic [7:0] ch, input logic first,
                             input logic [15:0] ox, input logic [15:0] oy);
        int gap;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge aclk);
            // mostly short bursts, now and then a long unbroken stretch
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {oy, ox, ch};
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    // Coordinates: full range, near either rail, or small
    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 4))
            0:       return 16'h7FFF - 16'($urandom_range(0, 40));
            1:       return 16'h8000 + 16'($urandom_range(0, 40));
            2:       return 16'($urandom_range(0, 400)) - 16'd200;
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver: pick a new stall pattern whenever the mode timer runs out
    always @(posedge aclk) begin
        if (mode_timer == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            mode_timer = $urandom_range(50, 300);
        end
        mode_timer--;
        case (rx_mode)
            RX_OPEN: begin
                m_tready <= 1'b1;
            end
            RX_COIN: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 12);
                end
            end
        endcase
    end

    initial begin
        logic [7:0]  ch;
        logic        first;
        logic [15:0] ox;
        logic [15:0] oy;
        int          sent;
        int          len;
        int          pick;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: rails, the result cap, case folding, blank and unknown codes
        send_char("0", 1'b1, 16'h0000, 16'h0000);
        send_char("M", 1'b1, 16'h7FFB, 16'h7FFD);
        send_char("m", 1'b0, 16'h0000, 16'h7FFF);
        send_char("s", 1'b0, 16'hFFFF, 16'h7FF0);
        send_char("M", 1'b1, 16'h8000, 16'h8000);
        send_char("f", 1'b0, 16'h1234, 16'h8000);
        send_char("p", 1'b0, 16'h0000, 16'hFFFF);
        send_char("S", 1'b0, 16'h0000, 16'h0010);
        send_char("F", 1'b0, 16'h0000, 16'h0010);
        send_char("P", 1'b0, 16'h0000, 16'h0010);
        send_char(" ", 1'b0, 16'h0000, 16'h0010);
        send_char(".", 1'b0, 16'h0000, 16'h0010);
        send_char(8'h00, 1'b0, 16'hFFFF, 16'hFFFF);
        send_char(8'hFF, 1'b1, 16'h7FFF, 16'h0000);
        send_char("z", 1'b0, 16'h0000, 16'h0000);
        send_char("a", 1'b0, 16'h0000, 16'h0000);
        for (int d = 1; d <= 9; d++) begin
            send_char(8'h30 + 8'(d), (d == 1), 16'h0100, 16'h0040);
        end
        directed_count = 25;

        // Random strings: mostly font characters, some noise and lower case
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            len = $urandom_range(1, 12);
            ox = pick_coord();
            oy = pick_coord();
            for (int k = 0; k < len && sent < RANDOM_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    ch = text_set[$urandom_range(0, text_set.len() - 1)];
                else if (pick < 88)
                    ch = 8'($urandom);
                else
                    ch = 8'($urandom_range(8'h61, 8'h7A));
                if (k == 0)
                    first = ($urandom_range(0, 9) != 0);
                else
                    first = ($urandom_range(0, 19) == 0);
                if (first && k > 0) ox = pick_coord();
                if ($urandom_range(0, 9) == 0) oy = pick_coord();
                send_char(ch, first, ox, oy);
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then give the block time to show any stray rectangle
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d characters (%0d directed, %0d random), checked %0d rectangles",
                 char_total, directed_count, char_total - directed_count, rect_total);
        $display("Mismatches: %0d, rectangles still expected: %0d", fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Guard against a hang
    initial begin
        #12000000;
        $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/grrr_pkg.sv
rtl/grrr_ctrl.sv
rtl/grrr_dp.sv
rtl/glyph_row_run_rectangles.sv
dv/glyph_rect_checker.sv
dv/tb.sv
